@@ rtl/assert_macros.svh @@
// Assertion macros for the gradient noise RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define GN_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the default clock and reset names.
`define GN_ASSERT(lbl, prop, msg) `GN_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ rtl/gn2d_pkg.sv @@
// Shared constants for the 2D gradient noise pipeline.
package gn2d_pkg;

    localparam int IN_W          = 32;
    localparam int OUT_W         = 26;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [31:0] HASH_MUL  = 32'd1664525;
    localparam logic [31:0] HASH_ADD  = 32'd1013904223;
    localparam logic [31:0] HASH_MIX1 = 32'd2246822519;
    localparam logic [31:0] HASH_MIX2 = 32'd3266489917;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

@@ rtl/gradient_noise_2d_with_derivatives.sv @@
// Top level: 2D gradient noise with analytic derivatives, ten-stage pipeline.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_x_pos, i_y_pos
//  out     | output    | o_out_valid / i_out_ready | o_noise_value, o_deriv_x, o_deriv_y
//
// One transaction per cycle while the output does not stall; results leave from the output register.
// Stages: corner hash (five dependent 32-bit multiplies), dot products, blend products,
// derivative products, final sum and saturation.
// Synchronous active-low reset clears only the stage valid bits.
// A stall at the output freezes the whole pipe; o_in_ready drops only while the last
// stage holds a transaction that is not taken.
`include "assert_macros.svh"

module gradient_noise_2d_with_derivatives #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [gn2d_pkg::IN_W-1:0]   i_x_pos,
    input  logic signed [gn2d_pkg::IN_W-1:0]   i_y_pos,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [gn2d_pkg::OUT_W-1:0]  o_noise_value,
    output logic signed [gn2d_pkg::OUT_W-1:0]  o_deriv_x,
    output logic signed [gn2d_pkg::OUT_W-1:0]  o_deriv_y
);
    import gn2d_pkg::*;

    localparam int VW   = FRAC_BITS + 7;
    localparam int SW   = (VW > OUT_W) ? VW : OUT_W;
    localparam int NSTG = 10;

    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [OUT_W-1:0] t_out;

    localparam t_val ONE = t_val'(1) << FRAC_BITS;
    localparam logic signed [2*VW-1:0] RND = (2*VW)'(1) << (FRAC_BITS - 1);

    function automatic t_val fmul(input t_val a, input t_val b);
        logic signed [2*VW-1:0] p;
        p = a * b + RND;
        return t_val'(p >>> FRAC_BITS);
    endfunction

    function automatic t_out sat(input t_val v);
        logic signed [SW-1:0] e;
        e = SW'(v);
        if (e > SW'(OUT_MAX)) return OUT_MAX;
        if (e < SW'(OUT_MIN)) return OUT_MIN;
        return t_out'(e);
    endfunction

    logic            en;
    logic [NSTG-1:0] r_vld;

    logic [31:0] n_ix, n_iy;
    t_val        gx [4];
    t_val        gy [4];
    t_val        fade_ux, fade_dux, fade_uy, fade_duy;

    t_val r_fx [5];
    t_val r_fy [5];
    t_val r_ux [2];
    t_val r_uy [2];
    t_val r_dux [5];
    t_val r_duy [5];

    t_val n_fxm, n_fym;

    t_val r6_va, r6_vb, r6_vc, r6_vd, r6_uxy, r6_ux, r6_uy;
    t_val r6_gx [4];
    t_val r6_gy [4];

    t_val r7_va, r7_dvb, r7_dvc, r7_k, r7_gax, r7_gay;
    t_val r7_dgbx, r7_dgcx, r7_dgkx, r7_dgby, r7_dgcy, r7_dgky;
    t_val r7_ux, r7_uy, r7_uxy;

    t_val r8_va, r8_dvb, r8_dvc, r8_gax, r8_gay;
    t_val r8_pvb, r8_pvc, r8_pk;
    t_val r8_pgbx, r8_pgcx, r8_pgkx, r8_pgby, r8_pgcy, r8_pgky;
    t_val r8_puyk, r8_puxk;

    t_val r9_val, r9_sdx, r9_sdy, r9_mdx, r9_mdy;

    t_out r_noise, r_dx, r_dy;

    assign en          = i_out_ready | ~r_vld[NSTG-1];
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTG-1];

    assign n_ix = 32'(i_x_pos >>> FRAC_BITS);
    assign n_iy = 32'(i_y_pos >>> FRAC_BITS);

    gn2d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ix  (n_ix),
        .i_iy  (n_iy),
        .o_gx  (gx),
        .o_gy  (gy)
    );

    gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (i_x_pos[FRAC_BITS-1:0]),
        .o_u   (fade_ux),
        .o_du  (fade_dux)
    );

    gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (i_y_pos[FRAC_BITS-1:0]),
        .o_u   (fade_uy),
        .o_du  (fade_duy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    assign n_fxm = r_fx[4] - ONE;
    assign n_fym = r_fy[4] - ONE;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // delay lines to line up fractions and fades with the hash
            r_fx[0] <= t_val'({1'b0, i_x_pos[FRAC_BITS-1:0]});
            r_fy[0] <= t_val'({1'b0, i_y_pos[FRAC_BITS-1:0]});
            for (int s = 1; s < 5; s++) begin
                r_fx[s]  <= r_fx[s-1];
                r_fy[s]  <= r_fy[s-1];
                r_dux[s] <= r_dux[s-1];
                r_duy[s] <= r_duy[s-1];
            end
            r_ux[0]  <= fade_ux;
            r_uy[0]  <= fade_uy;
            r_ux[1]  <= r_ux[0];
            r_uy[1]  <= r_uy[0];
            r_dux[0] <= fade_dux;
            r_duy[0] <= fade_duy;

            // corner dot products
            r6_va  <= fmul(gx[0], r_fx[4]) + fmul(gy[0], r_fy[4]);
            r6_vb  <= fmul(gx[1], n_fxm)   + fmul(gy[1], r_fy[4]);
            r6_vc  <= fmul(gx[2], r_fx[4]) + fmul(gy[2], n_fym);
            r6_vd  <= fmul(gx[3], n_fxm)   + fmul(gy[3], n_fym);
            r6_uxy <= fmul(r_ux[1], r_uy[1]);
            r6_ux  <= r_ux[1];
            r6_uy  <= r_uy[1];
            r6_gx  <= gx;
            r6_gy  <= gy;

            r7_va   <= r6_va;
            r7_dvb  <= r6_vb - r6_va;
            r7_dvc  <= r6_vc - r6_va;
            r7_k    <= r6_va - r6_vb - r6_vc + r6_vd;
            r7_gax  <= r6_gx[0];
            r7_gay  <= r6_gy[0];
            r7_dgbx <= r6_gx[1] - r6_gx[0];
            r7_dgcx <= r6_gx[2] - r6_gx[0];
            r7_dgkx <= r6_gx[0] - r6_gx[1] - r6_gx[2] + r6_gx[3];
            r7_dgby <= r6_gy[1] - r6_gy[0];
            r7_dgcy <= r6_gy[2] - r6_gy[0];
            r7_dgky <= r6_gy[0] - r6_gy[1] - r6_gy[2] + r6_gy[3];
            r7_ux   <= r6_ux;
            r7_uy   <= r6_uy;
            r7_uxy  <= r6_uxy;

            r8_va   <= r7_va;
            r8_dvb  <= r7_dvb;
            r8_dvc  <= r7_dvc;
            r8_gax  <= r7_gax;
            r8_gay  <= r7_gay;
            r8_pvb  <= fmul(r7_ux, r7_dvb);
            r8_pvc  <= fmul(r7_uy, r7_dvc);
            r8_pk   <= fmul(r7_uxy, r7_k);
            r8_pgbx <= fmul(r7_ux, r7_dgbx);
            r8_pgcx <= fmul(r7_uy, r7_dgcx);
            r8_pgkx <= fmul(r7_uxy, r7_dgkx);
            r8_pgby <= fmul(r7_ux, r7_dgby);
            r8_pgcy <= fmul(r7_uy, r7_dgcy);
            r8_pgky <= fmul(r7_uxy, r7_dgky);
            r8_puyk <= fmul(r7_uy, r7_k);
            r8_puxk <= fmul(r7_ux, r7_k);

            r9_val <= r8_va + r8_pvb + r8_pvc + r8_pk;
            r9_sdx <= r8_gax + r8_pgbx + r8_pgcx + r8_pgkx;
            r9_sdy <= r8_gay + r8_pgby + r8_pgcy + r8_pgky;
            r9_mdx <= fmul(r_dux[4], t_val'(r8_puyk + r8_dvb));
            r9_mdy <= fmul(r_duy[4], t_val'(r8_puxk + r8_dvc));

            r_noise <= sat(r9_val);
            r_dx    <= sat(t_val'(r9_sdx + r9_mdx));
            r_dy    <= sat(t_val'(r9_sdy + r9_mdy));
        end
    end

    assign o_noise_value = r_noise;
    assign o_deriv_x     = r_dx;
    assign o_deriv_y     = r_dy;

    `GN_ASSERT(a_stall_blocks_input, (o_out_valid && !i_out_ready) |-> !o_in_ready, "input taken during output stall")
    `GN_ASSERT(a_empty_tail_ready, !o_out_valid |-> o_in_ready, "input blocked with empty output stage")
    `GN_ASSERT(a_accept_enters, (i_in_valid && o_in_ready) |=> r_vld[0], "accepted transaction lost at stage one")

endmodule

@@ rtl/gn2d_hash.sv @@
// Five-stage corner hash: cell indexes in, four corner gradient vectors out.
module gn2d_hash #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [31:0]              i_ix,
    input  logic [31:0]              i_iy,
    output logic signed [FRAC_BITS+6:0] o_gx [4],
    output logic signed [FRAC_BITS+6:0] o_gy [4]
);
    import gn2d_pkg::*;

    localparam int VW = FRAC_BITS + 7;
    localparam int SH = 31 - FRAC_BITS;

    typedef logic signed [VW-1:0] t_val;

    logic [31:0] r_a0 [2];
    logic [31:0] r_b0 [2];
    logic [31:0] r_a1 [4];
    logic [31:0] r_b0c [4];
    logic [31:0] r_b1 [4];
    logic [31:0] r_a1c [4];
    logic [31:0] r_a2 [4];
    logic [31:0] r_b1c [4];
    t_val        r_gx [4];
    t_val        r_gy [4];

    logic [31:0] n_b2 [4];
    logic [31:0] n_a3 [4];
    logic [31:0] n_b3 [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_b2[c] = r_b1c[c] + r_a2[c] * HASH_MUL;
            n_a3[c] = r_a2[c] ^ (r_a2[c] >> 16);
            n_b3[c] = n_b2[c] ^ (n_b2[c] >> 16);
        end
    end

    // corner c: x neighbor on bit 0, y neighbor on bit 1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0[0] <= i_ix * HASH_MUL + HASH_ADD;
            r_a0[1] <= (i_ix + 32'd1) * HASH_MUL + HASH_ADD;
            r_b0[0] <= i_iy * HASH_MUL + HASH_ADD;
            r_b0[1] <= (i_iy + 32'd1) * HASH_MUL + HASH_ADD;
            for (int c = 0; c < 4; c++) begin
                r_a1[c]  <= r_a0[c & 1] ^ (r_b0[(c >> 1) & 1] * HASH_MIX1);
                r_b0c[c] <= r_b0[(c >> 1) & 1];
                r_b1[c]  <= r_b0c[c] ^ (r_a1[c] * HASH_MIX2);
                r_a1c[c] <= r_a1[c];
                r_a2[c]  <= r_a1c[c] + r_b1[c] * HASH_MUL;
                r_b1c[c] <= r_b1[c];
                r_gx[c]  <= t_val'($signed(n_a3[c]) >>> SH);
                r_gy[c]  <= t_val'($signed(n_b3[c]) >>> SH);
            end
        end
    end

    assign o_gx = r_gx;
    assign o_gy = r_gy;

endmodule

@@ rtl/gn2d_fade.sv @@
// Three-stage quintic fade u(t) and its derivative du(t).
module gn2d_fade #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [FRAC_BITS-1:0]        i_t,
    output logic signed [FRAC_BITS+6:0] o_u,
    output logic signed [FRAC_BITS+6:0] o_du
);
    import gn2d_pkg::*;

    localparam int VW = FRAC_BITS + 7;

    typedef logic signed [VW-1:0] t_val;

    localparam t_val ONE = t_val'(1) << FRAC_BITS;
    localparam logic signed [2*VW-1:0] RND = (2*VW)'(1) << (FRAC_BITS - 1);

    function automatic t_val fmul(input t_val a, input t_val b);
        logic signed [2*VW-1:0] p;
        p = a * b + RND;
        return t_val'(p >>> FRAC_BITS);
    endfunction

    t_val n_t;
    t_val r_t, r_t2, r_in1, r_in2;
    t_val r_t3, r_du, r_in1b;
    t_val r_u, r_du2;

    assign n_t = t_val'({1'b0, i_t});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= n_t;
            r_t2   <= fmul(n_t, n_t);
            r_in1  <= t_val'(fmul(n_t, t_val'(n_t * 6 - ONE * 15)) + ONE * 10);
            r_in2  <= t_val'(fmul(n_t, t_val'(n_t - ONE * 2)) + ONE);
            r_t3   <= fmul(r_t2, r_t);
            r_du   <= fmul(t_val'(r_t2 * 30), r_in2);
            r_in1b <= r_in1;
            r_u    <= fmul(r_t3, r_in1b);
            r_du2  <= r_du;
        end
    end

    assign o_u  = r_u;
    assign o_du = r_du2;

endmodule

@@ verif/tb_gradient_noise_2d_with_derivatives.sv @@
// Testbench for the 2D gradient noise block: directed table plus random points, scoreboarded.
module tb_gradient_noise_2d_with_derivatives;
    import gn2d_pkg::*;

    localparam int F       = FRAC_BITS_DEF;
    localparam int N_RAND  = 1900;
    localparam int N_DIR   = 14;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic signed [OUT_W-1:0] noise;
        logic signed [OUT_W-1:0] dx;
        logic signed [OUT_W-1:0] dy;
    } t_sample_res;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [IN_W-1:0] i_x_pos, i_y_pos;
    logic signed [OUT_W-1:0] o_noise_value, o_deriv_x, o_deriv_y;

    t_sample_res expected_q[$];
    int   mismatches = 0;
    longint cycles = 0;
    int   send_idle_pct, recv_idle_pct;
    bit   done_sending;

    gradient_noise_2d_with_derivatives u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_x_pos(i_x_pos), .i_y_pos(i_y_pos),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_noise_value(o_noise_value), .o_deriv_x(o_deriv_x), .o_deriv_y(o_deriv_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // fixed-point product, rounded half up, floor shift
    function automatic longint fx_mul(longint a, longint b);
        return (a * b + (longint'(1) << (F - 1))) >>> F;
    endfunction

    function automatic void corner_gradient(input logic [31:0] cx, input logic [31:0] cy,
                                            output longint gx, output longint gy);
        logic [31:0] a, b;
        a = cx * HASH_MUL + HASH_ADD;
        b = cy * HASH_MUL + HASH_ADD;
        a = a ^ (b * HASH_MIX1);
        b = b ^ (a * HASH_MIX2);
        a = a + b * HASH_MUL;
        b = b + a * HASH_MUL;
        a = a ^ (a >> 16);
        b = b ^ (b >> 16);
        gx = longint'($signed(a)) >>> (31 - F);
        gy = longint'($signed(b)) >>> (31 - F);
    endfunction

    function automatic void quintic_fade(input longint t, output longint u, output longint du);
        longint one, t2, t3, inner;
        one = longint'(1) << F;
        t2 = fx_mul(t, t);
        t3 = fx_mul(t2, t);
        inner = fx_mul(t, 6 * t - 15 * one) + 10 * one;
        u = fx_mul(t3, inner);
        inner = fx_mul(t, t - 2 * one) + one;
        du = fx_mul(30 * t2, inner);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
        if (v > longint'(OUT_MAX)) return OUT_MAX;
        if (v < longint'(OUT_MIN)) return OUT_MIN;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_sample_res noise_at(logic signed [31:0] xp, logic signed [31:0] yp);
        longint one, fx, fy, ux, uy, dux, duy, gax, gay, gbx, gby, gcx, gcy, gdx, gdy;
        longint va, vb, vc, vd, k, uxy, val, dx, dy;
        logic [31:0] ix, iy;
        t_sample_res r;
        one = longint'(1) << F;
        ix = 32'(longint'(xp) >>> F);
        iy = 32'(longint'(yp) >>> F);
        fx = longint'(xp) & (one - 1);
        fy = longint'(yp) & (one - 1);
        quintic_fade(fx, ux, dux);
        quintic_fade(fy, uy, duy);
        corner_gradient(ix, iy, gax, gay);
        corner_gradient(ix + 32'd1, iy, gbx, gby);
        corner_gradient(ix, iy + 32'd1, gcx, gcy);
        corner_gradient(ix + 32'd1, iy + 32'd1, gdx, gdy);
        va = fx_mul(gax, fx) + fx_mul(gay, fy);
        vb = fx_mul(gbx, fx - one) + fx_mul(gby, fy);
        vc = fx_mul(gcx, fx) + fx_mul(gcy, fy - one);
        vd = fx_mul(gdx, fx - one) + fx_mul(gdy, fy - one);
        k = va - vb - vc + vd;
        uxy = fx_mul(ux, uy);
        val = va + fx_mul(ux, vb - va) + fx_mul(uy, vc - va) + fx_mul(uxy, k);
        dx = gax + fx_mul(ux, gbx - gax) + fx_mul(uy, gcx - gax)
           + fx_mul(uxy, gax - gbx - gcx + gdx) + fx_mul(dux, fx_mul(uy, k) + (vb - va));
        dy = gay + fx_mul(ux, gby - gay) + fx_mul(uy, gcy - gay)
           + fx_mul(uxy, gay - gby - gcy + gdy) + fx_mul(duy, fx_mul(ux, k) + (vc - va));
        r.noise = clamp_out(val);
        r.dx = clamp_out(dx);
        r.dy = clamp_out(dy);
        return r;
    endfunction

    // directed points: extremes, cell wrap at both ends, integer grid, fractions near 1
    logic [31:0] dir_x [N_DIR] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h7FFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_FFFF,
        32'h0000_8000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0123_4567};
    logic [31:0] dir_y [N_DIR] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h7FFF_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_FFFF,
        32'h0000_8000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
        32'hFEDC_BA98};

    // valid drops only on idle cycles, so back-to-back transactions keep it high
    task automatic send_point(logic [31:0] xp, logic [31:0] yp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_x_pos <= xp;
        i_y_pos <= yp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q = {expected_q, noise_at(xp, yp)};
    endtask

    task automatic send_phase(int n);
        logic [31:0] xp, yp;
        for (int i = 0; i < n; i++) begin
            xp = $urandom;
            yp = $urandom;
            // a quarter of points stay in a modest range, a quarter sit on x cell edges
            case ($urandom_range(3))
                0: begin
                    xp = {{12{xp[31]}}, xp[19:0]};
                    yp = {{12{yp[31]}}, yp[19:0]};
                end
                1: xp[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: ;
            endcase
            send_point(xp, yp);
        end
    endtask

    // output side: ready toggling and scoreboard
    always @(posedge i_clk) begin
        t_sample_res e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
                end else begin
                    e = expected_q.pop_front();
                    if (e.noise !== o_noise_value || e.dx !== o_deriv_x
                        || e.dy !== o_deriv_y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                     e.noise, e.dx, e.dy,
                                     o_noise_value, o_deriv_x, o_deriv_y);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_x_pos = '0;
        i_y_pos = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 14;
        recv_idle_pct = 48;
        for (int i = 0; i < N_DIR; i++) send_point(dir_x[i], dir_y[i]);
        send_phase(N_RAND / 3);
        send_idle_pct = 48;
        recv_idle_pct = 14;
        send_phase(N_RAND / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_phase(N_RAND / 3);
        i_in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
